FILE: rtl/sync_xor_frame_deframer_defines.svh
// Assertion macros used by the deframer parser module.
`ifndef SYNC_XOR_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_XOR_FRAME_DEFRAMER_DEFINES_SVH

// The expression holds at every clock edge out of reset.
`define SXFD_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("sxfd: invariant violated");

// The consequent holds in the cycle after the antecedent.
`define SXFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sxfd: sequence check failed");

`endif

FILE: rtl/sxfd_pkg.sv
package sxfd_pkg;

    localparam int POS_W       = 5;
    localparam int STORE_DEPTH = 21;

    localparam logic [7:0]       HDR_BYTE  = 8'h7E;
    localparam logic [POS_W-1:0] POS_HDR0  = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1  = 5'd1;
    localparam logic [POS_W-1:0] POS_DATA0 = 5'd2;
    localparam logic [POS_W-1:0] LAST_DATA = 5'd22;
    localparam logic [POS_W-1:0] CHK_POS   = 5'd23;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] angle_inc_x;
        logic signed [31:0] angle_inc_y;
        logic signed [31:0] attitude_second;
        logic signed [31:0] attitude_first;
        logic        [31:0] clock_count;
        logic        [7:0]  mode_byte;
    } sxfd_result_t;

endpackage

FILE: rtl/sxfd_parser.sv
`include "sync_xor_frame_deframer_defines.svh"

module sxfd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 process,
    input  logic [7:0]           rx_byte,
    output sxfd_pkg::sxfd_result_t result
);
    import sxfd_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic             shift_en;
    logic [7:0]       store_reg [STORE_DEPTH];

    always_comb begin
        pos_next = pos_reg;
        xor_next = xor_reg;
        shift_en = 1'b0;
        result   = '0;
        if (process) begin
            if (pos_reg == POS_HDR0) begin
                pos_next = (rx_byte == HDR_BYTE) ? POS_HDR1 : POS_HDR0;
            end else if (pos_reg == POS_HDR1) begin
                if (rx_byte == HDR_BYTE) begin
                    pos_next = POS_DATA0;
                    xor_next = 8'h00;
                end else begin
                    pos_next = POS_HDR0;
                end
            end else if (pos_reg <= LAST_DATA) begin
                shift_en = 1'b1;
                xor_next = xor_reg ^ rx_byte;
                pos_next = pos_reg + 5'd1;
            end else if (pos_reg == CHK_POS) begin
                pos_next     = POS_HDR0;
                result.valid = (rx_byte == xor_reg);
            end else begin
                pos_next = POS_HDR0;
            end
        end
        result.angle_inc_x     = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
        result.angle_inc_y     = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
        result.attitude_second = {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
        result.attitude_first  = {store_reg[15], store_reg[14], store_reg[13], store_reg[12]};
        result.clock_count     = {store_reg[19], store_reg[18], store_reg[17], store_reg[16]};
        result.mode_byte       = store_reg[20];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HDR0;
            xor_reg <= 8'h00;
        end else begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
        end
    end

    // Payload bytes shift in at the top, so frame byte 2 ends up in entry 0.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < STORE_DEPTH - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[STORE_DEPTH-1] <= rx_byte;
        end
    end

    `SXFD_ASSERT_ALWAYS(a_pos_range, aclk, aresetn, pos_reg <= CHK_POS)
    `SXFD_ASSERT_NEXT(a_hdr_clears_xor, aclk, aresetn,
        process && pos_reg == POS_HDR1 && rx_byte == HDR_BYTE,
        pos_reg == POS_DATA0 && xor_reg == 8'h00)
    `SXFD_ASSERT_NEXT(a_chk_to_hunt, aclk, aresetn,
        process && pos_reg == CHK_POS, pos_reg == POS_HDR0)
    `SXFD_ASSERT_NEXT(a_idle_holds, aclk, aresetn,
        !process, $stable(pos_reg) && $stable(xor_reg))

endmodule

FILE: rtl/sxfd_out_reg.sv
module sxfd_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sxfd_pkg::sxfd_result_t result,
    output logic                   advance,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_angle_inc_x,
    output logic signed [31:0]     m_angle_inc_y,
    output logic signed [31:0]     m_attitude_second,
    output logic signed [31:0]     m_attitude_first,
    output logic        [31:0]     m_clock_count,
    output logic        [7:0]      m_mode_byte
);
    import sxfd_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    sxfd_result_t data_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? result.valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            data_reg <= result;
        end
    end

    assign m_valid           = valid_reg;
    assign m_angle_inc_x     = data_reg.angle_inc_x;
    assign m_angle_inc_y     = data_reg.angle_inc_y;
    assign m_attitude_second = data_reg.attitude_second;
    assign m_attitude_first  = data_reg.attitude_first;
    assign m_clock_count     = data_reg.clock_count;
    assign m_mode_byte       = data_reg.mode_byte;

endmodule

FILE: rtl/sync_xor_frame_deframer.sv
// Fixed 24-byte frame parser: it hunts for two 0x7E header bytes, captures
// bytes 2 to 22, and emits one decoded request when byte 23 equals the XOR of
// bytes 2 to 22; frames with a bad checksum are dropped silently. One byte is
// accepted every cycle while the output register is not stalled, and a result
// reaches the output after its checksum byte is held in the input register
// and parsed on its way into the output register. The only stall source is
// the output register held by a low m_ready.
module sync_xor_frame_deframer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_angle_inc_x,
    output logic signed [31:0] m_angle_inc_y,
    output logic signed [31:0] m_attitude_second,
    output logic signed [31:0] m_attitude_first,
    output logic        [31:0] m_clock_count,
    output logic        [7:0]  m_mode_byte
);
    import sxfd_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         advance;
    logic         process;
    sxfd_result_t result;

    assign process       = in_valid_reg && advance;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    sxfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .process (process),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    sxfd_out_reg u_out_reg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .result            (result),
        .advance           (advance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_angle_inc_x     (m_angle_inc_x),
        .m_angle_inc_y     (m_angle_inc_y),
        .m_attitude_second (m_attitude_second),
        .m_attitude_first  (m_attitude_first),
        .m_clock_count     (m_clock_count),
        .m_mode_byte       (m_mode_byte)
    );

endmodule
